[rtl/fcce_pkg.sv]
// ----------------------------------------------------------------------------
// fcce_pkg
// Shared codes, constants and controller/datapath interface types for the
// FAT32 cluster chain engine.
// ----------------------------------------------------------------------------
package fcce_pkg;

  // request function codes
  localparam logic [2:0] FUNC_WALK  = 3'd0;
  localparam logic [2:0] FUNC_WRITE = 3'd1;
  localparam logic [2:0] FUNC_FREE  = 3'd2;
  localparam logic [2:0] FUNC_LOAD  = 3'd3;
  localparam logic [2:0] FUNC_READ  = 3'd4;
  localparam logic [2:0] FUNC_SET   = 3'd5;

  // result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_SPACE = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_BAD      = 3'd3;
  localparam logic [2:0] ST_CONTINUE = 3'd4;

  // configuration register indexes
  localparam logic [1:0] REG_DATA_START = 2'd0;
  localparam logic [1:0] REG_SECT_CLUS  = 2'd1;
  localparam logic [1:0] REG_CLUS_TOTAL = 2'd2;

  // table word constants
  localparam logic [31:0] LINK_MASK = 32'h0FFF_FFFF;
  localparam logic [31:0] END_MIN   = 32'h0FFF_FFF8;
  localparam logic [31:0] BAD_WORD  = 32'h0FFF_FFF7;
  localparam logic [31:0] END_WORD  = 32'hFFFF_FFFF;
  localparam logic [31:0] NO_HINT   = 32'hFFFF_FFFF;
  localparam logic [31:0] FREE_WORD = 32'h0000_0000;
  localparam logic [31:0] MAX_COUNT = 32'hFFFF_FFFF;

  // datapath micro-operations
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LATCH,
    OP_DISPATCH,
    OP_CH_CHECK,
    OP_CH_STEP,
    OP_CH_END,
    OP_SC_CHECK,
    OP_SC_STEP,
    OP_SC_DONE,
    OP_WR_READ,
    OP_WR_UPD,
    OP_WR_LINK,
    OP_FT_CHECK,
    OP_FT_STEP,
    OP_WR_DONE,
    OP_RD_DONE,
    OP_SGL_OUT,
    OP_DR_READ,
    OP_DR_MUL,
    OP_DR_OUT
  } op_t;

  typedef struct packed {
    op_t  op;
    logic scan_first;   // free scan serves the first cluster of a write
  } cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       wr_zero;
    logic       wr_nospace;
    logic       use_start;
    logic       start_usable;
    logic       big_index;
    logic       ch_end;
    logic       ch_full;
    logic       ch_bad;
    logic       ch_empty;
    logic       sc_end;
    logic       sc_free;
    logic       wr_last;
    logic       old_usable;
    logic       out_free;
    logic       dr_last;
  } stat_t;

endpackage

[rtl/fcce_ctrl.sv]
// ----------------------------------------------------------------------------
// fcce_ctrl
// Request sequencer: steps through chain walks, free scans, chain writes,
// tail frees, single results and the result drain, issuing one micro-op per cycle.
// ----------------------------------------------------------------------------
module fcce_ctrl import fcce_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_DISPATCH = 5'd1;
  localparam logic [4:0] S_CH_CHECK = 5'd2;
  localparam logic [4:0] S_CH_STEP  = 5'd3;
  localparam logic [4:0] S_CH_END   = 5'd4;
  localparam logic [4:0] S_SC_CHECK = 5'd5;
  localparam logic [4:0] S_SC_STEP  = 5'd6;
  localparam logic [4:0] S_SC_DONE  = 5'd7;
  localparam logic [4:0] S_WR_READ  = 5'd8;
  localparam logic [4:0] S_WR_UPD   = 5'd9;
  localparam logic [4:0] S_WR_LINK  = 5'd10;
  localparam logic [4:0] S_FT_CHECK = 5'd11;
  localparam logic [4:0] S_FT_STEP  = 5'd12;
  localparam logic [4:0] S_WR_DONE  = 5'd13;
  localparam logic [4:0] S_RD_WAIT  = 5'd14;
  localparam logic [4:0] S_SGL      = 5'd15;
  localparam logic [4:0] S_DR_READ  = 5'd16;
  localparam logic [4:0] S_DR_MUL   = 5'd17;
  localparam logic [4:0] S_DR_OUT   = 5'd18;

  logic [4:0] state, state_next;
  logic       scan_first, scan_first_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      scan_first <= 1'b0;
    end else begin
      state      <= state_next;
      scan_first <= scan_first_next;
    end
  end

  // next state and command
  always_comb begin
    state_next      = state;
    scan_first_next = scan_first;
    cmd.op          = OP_NONE;
    cmd.scan_first  = scan_first;
    in_stall        = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.op     = OP_LATCH;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd.op = OP_DISPATCH;
        unique case (stat.func)
          FUNC_WALK, FUNC_FREE: state_next = S_CH_CHECK;
          FUNC_WRITE: begin
            priority if (stat.wr_zero || stat.wr_nospace) begin
              state_next = S_SGL;
            end else if (stat.use_start) begin
              state_next = stat.start_usable ? S_WR_READ : S_SGL;
            end else begin
              scan_first_next = 1'b1;
              state_next      = S_SC_CHECK;
            end
          end
          FUNC_LOAD: state_next = S_SGL;
          FUNC_READ: state_next = stat.big_index ? S_SGL : S_RD_WAIT;
          default:   state_next = S_SGL;
        endcase
      end
      S_CH_CHECK: begin
        cmd.op = OP_CH_CHECK;
        if (stat.ch_end || stat.ch_full || stat.ch_bad) state_next = S_CH_END;
        else state_next = S_CH_STEP;
      end
      S_CH_STEP: begin
        cmd.op     = OP_CH_STEP;
        state_next = S_CH_CHECK;
      end
      S_CH_END: begin
        cmd.op     = OP_CH_END;
        state_next = stat.ch_empty ? S_SGL : S_DR_READ;
      end
      S_SC_CHECK: begin
        cmd.op     = OP_SC_CHECK;
        state_next = stat.sc_end ? S_SC_DONE : S_SC_STEP;
      end
      S_SC_STEP: begin
        cmd.op     = OP_SC_STEP;
        state_next = stat.sc_free ? S_SC_DONE : S_SC_CHECK;
      end
      S_SC_DONE: begin
        cmd.op = OP_SC_DONE;
        priority if (!stat.sc_end) state_next = S_WR_READ;
        else if (scan_first) state_next = S_SGL;
        else state_next = S_WR_DONE;
      end
      S_WR_READ: begin
        cmd.op     = OP_WR_READ;
        state_next = S_WR_UPD;
      end
      S_WR_UPD: begin
        cmd.op     = OP_WR_UPD;
        state_next = S_WR_LINK;
      end
      S_WR_LINK: begin
        cmd.op = OP_WR_LINK;
        priority if (stat.wr_last) begin
          state_next = S_FT_CHECK;
        end else if (stat.old_usable) begin
          state_next = S_WR_READ;
        end else begin
          scan_first_next = 1'b0;
          state_next      = S_SC_CHECK;
        end
      end
      S_FT_CHECK: begin
        cmd.op     = OP_FT_CHECK;
        state_next = stat.old_usable ? S_FT_STEP : S_WR_DONE;
      end
      S_FT_STEP: begin
        cmd.op     = OP_FT_STEP;
        state_next = S_FT_CHECK;
      end
      S_WR_DONE: begin
        cmd.op     = OP_WR_DONE;
        state_next = S_DR_READ;
      end
      S_RD_WAIT: begin
        cmd.op     = OP_RD_DONE;
        state_next = S_SGL;
      end
      S_SGL: begin
        cmd.op = OP_SGL_OUT;
        if (stat.out_free) state_next = S_IDLE;
      end
      S_DR_READ: begin
        cmd.op     = OP_DR_READ;
        state_next = S_DR_MUL;
      end
      S_DR_MUL: begin
        cmd.op     = OP_DR_MUL;
        state_next = S_DR_OUT;
      end
      S_DR_OUT: begin
        cmd.op = OP_DR_OUT;
        if (stat.out_free) state_next = stat.dr_last ? S_IDLE : S_DR_READ;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

[rtl/fcce_dp.sv]
// ----------------------------------------------------------------------------
// fcce_dp
// Datapath: allocation table memory, result buffer, counters, config
// registers, sector address multiply and the output register.
// ----------------------------------------------------------------------------
module fcce_dp import fcce_pkg::*; #(
  parameter int TABLE_ENTRIES = 65536,
  parameter int MAX_RUN       = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic [2:0]  func,
  input  logic [31:0] cluster,
  input  logic        use_start,
  input  logic [6:0]  run_length,
  input  logic [31:0] word_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [31:0] cluster_id,
  output logic [31:0] sector_address,
  output logic [31:0] entry_word,
  output logic [16:0] link_count,
  output logic [31:0] free_clusters,
  output logic        last
);

  localparam int TW  = $clog2(TABLE_ENTRIES);
  localparam int NW  = $clog2(MAX_RUN + 1);
  localparam int BAW = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;

  // memories
  logic [31:0] tbl [TABLE_ENTRIES];
  logic [63:0] rbuf [MAX_RUN];

  // latched request
  logic [2:0]  r_func;
  logic [31:0] r_cl;
  logic        r_use;
  logic [6:0]  r_rl;
  logic [31:0] r_word;

  // working registers
  logic [31:0] c, first, cur, prev, old, ptr;
  logic [NW-1:0] n, k;
  logic [2:0]  st, sgl_st;
  logic [31:0] sgl_id, sgl_entry;
  logic [31:0] fc, hint;
  logic [31:0] dss;
  logic [7:0]  spc;
  logic [16:0] ct;
  logic [31:0] trd;
  logic [63:0] bq;
  logic [31:0] dcl, dent, prod;

  // memory ports
  logic          tbl_we;
  logic [TW-1:0] tbl_wa, tbl_ra;
  logic [31:0]   tbl_wd;
  logic          buf_we;
  logic [BAW-1:0] buf_wa;
  logic [63:0]   buf_wd;

  logic [31:0] t_eff, rword, scan_init, fc_inc;
  logic [6:0]  cnt_eff;
  logic [NW-1:0] nm1;
  logic        release_op, load_sgl, load_dr;

  function automatic logic is_usable(input logic [31:0] v, input logic [31:0] lim);
    return (v >= 32'd2) && (v < lim);
  endfunction

  // derived values
  assign t_eff      = (32'(ct) > 32'(TABLE_ENTRIES)) ? 32'(TABLE_ENTRIES) : 32'(ct);
  assign rword      = trd & LINK_MASK;
  assign scan_init  = (hint == NO_HINT || hint < 32'd2) ? 32'd2 : hint;
  assign fc_inc     = (fc != MAX_COUNT) ? fc + 32'd1 : fc;
  assign cnt_eff    = (r_rl > 7'(MAX_RUN)) ? 7'(MAX_RUN) : r_rl;
  assign nm1        = n - NW'(1);
  assign release_op = (r_func == FUNC_FREE);

  // status to controller
  always_comb begin
    stat.func         = r_func;
    stat.wr_zero      = (cnt_eff == 7'd0);
    stat.wr_nospace   = (32'(cnt_eff) > fc);
    stat.use_start    = r_use;
    stat.start_usable = is_usable(r_cl, t_eff);
    stat.big_index    = (r_cl >= 32'(TABLE_ENTRIES));
    stat.ch_end       = (c >= END_MIN);
    stat.ch_full      = (n == NW'(MAX_RUN));
    stat.ch_bad       = (c == BAD_WORD) || !is_usable(c, t_eff);
    stat.ch_empty     = (n == '0);
    stat.sc_end       = (ptr >= t_eff);
    stat.sc_free      = (rword == FREE_WORD);
    stat.wr_last      = ((7'(n) + 7'd1) == cnt_eff);
    stat.old_usable   = is_usable(old, t_eff);
    stat.out_free     = !out_valid || !out_stall;
    stat.dr_last      = ((k + NW'(1)) == n);
  end

  assign load_sgl = (cmd.op == OP_SGL_OUT) && stat.out_free;
  assign load_dr  = (cmd.op == OP_DR_OUT) && stat.out_free;

  // table read address
  always_comb begin
    unique case (cmd.op)
      OP_DISPATCH: tbl_ra = r_cl[TW-1:0];
      OP_CH_CHECK: tbl_ra = c[TW-1:0];
      OP_SC_CHECK: tbl_ra = ptr[TW-1:0];
      OP_FT_CHECK: tbl_ra = old[TW-1:0];
      default:     tbl_ra = cur[TW-1:0];
    endcase
  end

  // table and buffer write ports
  always_comb begin
    tbl_we = 1'b0;
    tbl_wa = cur[TW-1:0];
    tbl_wd = END_WORD;
    buf_we = 1'b0;
    buf_wa = nm1[BAW-1:0];
    buf_wd = {prev, cur};
    unique case (cmd.op)
      OP_DISPATCH: begin
        tbl_we = (r_func == FUNC_LOAD) && !stat.big_index;
        tbl_wa = r_cl[TW-1:0];
        tbl_wd = r_word;
      end
      OP_CH_STEP: begin
        tbl_we = release_op;
        tbl_wa = c[TW-1:0];
        tbl_wd = FREE_WORD;
        buf_we = 1'b1;
        buf_wa = n[BAW-1:0];
        buf_wd = {c, rword};
      end
      OP_WR_UPD: tbl_we = 1'b1;
      OP_WR_LINK: begin
        tbl_we = (n != '0);
        tbl_wa = prev[TW-1:0];
        tbl_wd = cur;
        buf_we = (n != '0);
      end
      OP_FT_STEP: begin
        tbl_we = 1'b1;
        tbl_wa = old[TW-1:0];
        tbl_wd = FREE_WORD;
      end
      OP_WR_DONE: begin
        buf_we = 1'b1;
        buf_wd = {prev, END_WORD};
      end
      default: ;
    endcase
  end

  // memories, registered reads
  always_ff @(posedge clk) begin
    if (tbl_we) tbl[tbl_wa] <= tbl_wd;
    trd <= tbl[tbl_ra];
    if (buf_we) rbuf[buf_wa] <= buf_wd;
    bq <= rbuf[k[BAW-1:0]];
  end

  // config, counters and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      dss       <= 32'd0;
      spc       <= 8'd8;
      ct        <= 17'h10000;
      fc        <= 32'd0;
      hint      <= NO_HINT;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_DATA_START: dss <= cfg_data;
          REG_SECT_CLUS:  spc <= cfg_data[7:0];
          REG_CLUS_TOTAL: ct  <= cfg_data[16:0];
          default: ;
        endcase
      end
      unique case (cmd.op)
        OP_DISPATCH: begin
          if (r_func == FUNC_SET) begin
            fc   <= r_word;
            hint <= r_cl;
          end
        end
        OP_CH_STEP: if (release_op) fc <= fc_inc;
        OP_CH_END:  if (release_op && n != '0 && r_cl < hint) hint <= r_cl;
        OP_SC_DONE: hint <= ptr;
        OP_WR_UPD:  if (rword == FREE_WORD && fc != 32'd0) fc <= fc - 32'd1;
        OP_FT_STEP: fc <= fc_inc;
        default: ;
      endcase
      if (load_sgl || load_dr) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LATCH: begin
        r_func <= func;
        r_cl   <= cluster;
        r_use  <= use_start;
        r_rl   <= run_length;
        r_word <= word_value;
      end
      OP_DISPATCH: begin
        n     <= '0;
        st    <= ST_OK;
        c     <= (r_cl == 32'd0) ? END_WORD : r_cl;
        first <= r_cl;
        cur   <= r_cl;
        ptr   <= scan_init;
        unique case (r_func)
          FUNC_WRITE: begin
            sgl_id    <= 32'd0;
            sgl_entry <= 32'd0;
            priority if (stat.wr_zero) sgl_st <= ST_OK;
            else if (stat.wr_nospace) sgl_st <= ST_NO_SPACE;
            else sgl_st <= ST_BAD;
          end
          FUNC_LOAD, FUNC_READ: begin
            sgl_id    <= r_cl;
            sgl_st    <= stat.big_index ? ST_BAD : ST_OK;
            sgl_entry <= stat.big_index ? 32'd0 : r_word;
          end
          FUNC_SET: begin
            sgl_st    <= ST_OK;
            sgl_id    <= r_cl;
            sgl_entry <= 32'd0;
          end
          default: begin
            sgl_st    <= ST_OK;
            sgl_id    <= 32'd0;
            sgl_entry <= 32'd0;
          end
        endcase
      end
      OP_CH_CHECK: begin
        priority if (stat.ch_end) st <= ST_OK;
        else if (stat.ch_full) st <= ST_CONTINUE;
        else st <= ST_BAD;
      end
      OP_CH_STEP: begin
        c <= rword;
        n <= n + NW'(1);
      end
      OP_CH_END: begin
        k         <= '0;
        sgl_st    <= st;
        sgl_id    <= r_cl;
        sgl_entry <= 32'd0;
      end
      OP_SC_STEP: if (!stat.sc_free) ptr <= ptr + 32'd1;
      OP_SC_DONE: begin
        priority if (cmd.scan_first && stat.sc_end) begin
          sgl_st    <= ST_FULL;
          sgl_id    <= 32'd0;
          sgl_entry <= 32'd0;
        end else if (cmd.scan_first) begin
          first <= ptr;
          cur   <= ptr;
        end else if (stat.sc_end) begin
          st  <= ST_FULL;
          old <= FREE_WORD;
        end else begin
          cur <= ptr;
        end
      end
      OP_WR_UPD: old <= rword;
      OP_WR_LINK: begin
        prev <= cur;
        n    <= n + NW'(1);
        if (!stat.wr_last && stat.old_usable) cur <= old;
        if (!stat.wr_last && !stat.old_usable) ptr <= scan_init;
      end
      OP_FT_STEP: old <= rword;
      OP_WR_DONE: k <= '0;
      OP_RD_DONE: sgl_entry <= trd;
      OP_DR_MUL: begin
        dcl  <= bq[63:32];
        dent <= bq[31:0];
        prod <= 32'((bq[63:32] - 32'd2) * 32'(spc));
      end
      OP_DR_OUT: if (stat.out_free) k <= k + NW'(1);
      default: ;
    endcase

    // output register
    if (load_sgl) begin
      status         <= sgl_st;
      cluster_id     <= sgl_id;
      sector_address <= 32'd0;
      entry_word     <= sgl_entry;
      link_count     <= 17'd0;
      free_clusters  <= fc;
      last           <= 1'b1;
    end else if (load_dr) begin
      status         <= stat.dr_last ? st : ST_OK;
      cluster_id     <= stat.dr_last ? first : dcl;
      sector_address <= dss + prod;
      entry_word     <= dent;
      link_count     <= 17'(k) + 17'd1;
      free_clusters  <= fc;
      last           <= stat.dr_last;
    end
  end

endmodule

[rtl/fat_cluster_chain_engine.sv]
// Walks and frees visit one link at a time, a free scan probes one entry at a time, and a
// write places one link at a time plus any scan, then frees the old tail link by link.
// Results of a chain drain one by one from the result buffer and wait on output stalls;
// load, set, read, rejected requests and a walk or free with no link give a single result.
// One request at a time: the input reopens once the final result is loaded.
// Reset: controller, counters, hint and config reset; table undefined until written.
// ----------------------------------------------------------------------------
// fat_cluster_chain_engine
// FAT32 allocation table engine: chain walk, chain write with free scan,
// chain free, table load/read and counter set.
// ----------------------------------------------------------------------------
module fat_cluster_chain_engine import fcce_pkg::*; #(
  parameter int TABLE_ENTRIES = 65536,
  parameter int MAX_RUN       = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  func,
  input  logic [31:0] cluster,
  input  logic        use_start,
  input  logic [6:0]  run_length,
  input  logic [31:0] word_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [31:0] cluster_id,
  output logic [31:0] sector_address,
  output logic [31:0] entry_word,
  output logic [16:0] link_count,
  output logic [31:0] free_clusters,
  output logic        last
);

  cmd_t  cmd;
  stat_t stat;

  fcce_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  fcce_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .MAX_RUN       (MAX_RUN)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .func           (func),
    .cluster        (cluster),
    .use_start      (use_start),
    .run_length     (run_length),
    .word_value     (word_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .cluster_id     (cluster_id),
    .sector_address (sector_address),
    .entry_word     (entry_word),
    .link_count     (link_count),
    .free_clusters  (free_clusters),
    .last           (last)
  );

  // accepted transaction blocks the input until the request is done
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted twice in a row");

  // only the final result of a request carries a non-ok status
  a_status_on_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> last)
    else $error("error status on a non-final result");

  // intermediate results always come from the drain with a link count
  a_link_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last) |-> (link_count != 17'd0))
    else $error("intermediate result without link count");

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the FAT32 cluster chain engine. A local model of
// the allocation table, counters and hint predicts every result of each
// request; results are compared field by field in order. Requests that
// would read a never-written table entry are dropped before they are sent.
// ----------------------------------------------------------------------------
module tb_top;
  import fcce_pkg::*;

  localparam int TAB_SIZE       = 65536;
  localparam int MAX_LINKS      = 64;
  localparam int INIT_SPAN      = 80;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_ITEMS   = 150;
  localparam int QUIET_FROM     = 115;

  typedef struct {
    logic [2:0]  status;
    logic [31:0] cluster_id;
    logic [31:0] sector_address;
    logic [31:0] entry_word;
    logic [16:0] link_count;
    logic [31:0] free_clusters;
    logic        last;
  } link_result_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  func;
  logic [31:0] cluster;
  logic        use_start;
  logic [6:0]  run_length;
  logic [31:0] word_value;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  status;
  logic [31:0] cluster_id;
  logic [31:0] sector_address;
  logic [31:0] entry_word;
  logic [16:0] link_count;
  logic [31:0] free_clusters;
  logic        last;

  // model of the table and counters
  logic [31:0] fat_tab [int];
  logic [31:0] free_cnt;
  logic [31:0] hint;
  logic [31:0] base_sector;
  logic [7:0]  spc;
  logic [16:0] total_reg;
  bit          hit_unwritten;

  link_result_t step_out[$];
  link_result_t pending_results[$];

  int  error_count = 0;
  int  sent_count = 0;
  int  idle_cycles = 0;
  int  stall_left = 0;
  bit  quiet = 1'b0;

  always #2 clk = ~clk;

  fat_cluster_chain_engine dut (.*);

  // ---------------------------------------------------------------- model
  function automatic logic [31:0] eff_total();
    return (total_reg > TAB_SIZE) ? TAB_SIZE : {15'd0, total_reg};
  endfunction

  function automatic bit usable(logic [31:0] c);
    return c >= 32'd2 && c < eff_total();
  endfunction

  function automatic logic [31:0] sector_of(logic [31:0] c);
    return base_sector + (c - 32'd2) * {24'd0, spc};
  endfunction

  function automatic logic [31:0] tab_read(logic [31:0] idx);
    if (!fat_tab.exists(int'(idx))) begin
      hit_unwritten = 1'b1;
      return FREE_WORD;
    end
    return fat_tab[int'(idx)];
  endfunction

  function automatic void add_result(logic [2:0] st, logic [31:0] id, logic [31:0] sec,
                                     logic [31:0] word, int cnt, logic lst);
    link_result_t r;
    r.status = st;
    r.cluster_id = id;
    r.sector_address = sec;
    r.entry_word = word;
    r.link_count = cnt[16:0];
    r.free_clusters = '0;
    r.last = lst;
    step_out = {step_out, r};
  endfunction

  function automatic void close_request(logic [2:0] st, logic [31:0] first);
    int k;
    k = step_out.size() - 1;
    step_out[k].status = st;
    step_out[k].cluster_id = first;
    step_out[k].last = 1'b1;
  endfunction

  // free scan: from the hint, no wrap, hint left at the find or at the total
  function automatic logic [31:0] scan_free();
    logic [31:0] c;
    c = hint;
    if (c == NO_HINT || c < 32'd2) c = 32'd2;
    while (c < eff_total() && (tab_read(c) & LINK_MASK) != 32'd0) c++;
    hint = c;
    return c;
  endfunction

  // walk or free a chain
  function automatic void chain_pass(logic [31:0] start, bit release_links);
    logic [31:0] c, nx;
    logic [2:0]  st;
    int          n;
    c = (start == 32'd0) ? END_WORD : start;
    n = 0;
    while (1) begin
      if (c >= END_MIN) begin st = ST_OK; break; end
      if (n == MAX_LINKS) begin st = ST_CONTINUE; break; end
      if (c == BAD_WORD || !usable(c)) begin st = ST_BAD; break; end
      nx = tab_read(c) & LINK_MASK;
      if (release_links) begin
        fat_tab[int'(c)] = FREE_WORD;
        if (free_cnt != MAX_COUNT) free_cnt++;
      end
      add_result(ST_OK, c, sector_of(c), nx, n + 1, 1'b0);
      n++;
      c = nx;
    end
    if (n == 0) begin
      add_result(st, start, 32'd0, 32'd0, 0, 1'b1);
    end else begin
      if (release_links && start < hint) hint = start;
      close_request(st, start);
    end
  endfunction

  // write a chain, reusing links, scanning for free ones, freeing the tail
  function automatic void chain_write(logic us, logic [31:0] cl, logic [6:0] rl);
    logic [31:0] cnt, first, cur, prev, old, f, nx;
    logic [2:0]  st;
    int          n;
    cnt = {25'd0, rl};
    if (cnt > MAX_LINKS) cnt = MAX_LINKS;
    st = ST_OK;
    n = 0;
    prev = '0;
    if (cnt == 32'd0) begin
      add_result(ST_OK, 32'd0, 32'd0, 32'd0, 0, 1'b1);
      return;
    end
    if (cnt > free_cnt) begin
      add_result(ST_NO_SPACE, 32'd0, 32'd0, 32'd0, 0, 1'b1);
      return;
    end
    if (us) begin
      first = cl;
      if (!usable(first)) begin
        add_result(ST_BAD, 32'd0, 32'd0, 32'd0, 0, 1'b1);
        return;
      end
    end else begin
      first = scan_free();
      if (!usable(first)) begin
        add_result(ST_FULL, 32'd0, 32'd0, 32'd0, 0, 1'b1);
        return;
      end
    end
    cur = first;
    while (1) begin
      old = tab_read(cur) & LINK_MASK;
      fat_tab[int'(cur)] = END_WORD;
      if (old == 32'd0 && free_cnt != 32'd0) free_cnt--;
      add_result(ST_OK, cur, sector_of(cur), END_WORD, n + 1, 1'b0);
      if (n > 0) begin
        fat_tab[int'(prev)] = cur;
        step_out[n - 1].entry_word = cur;
      end
      prev = cur;
      n++;
      if (n == int'(cnt)) break;
      if (usable(old)) begin
        cur = old;
      end else begin
        f = scan_free();
        if (!usable(f)) begin st = ST_FULL; old = 32'd0; break; end
        cur = f;
      end
    end
    // orphaned links past the new end
    while (usable(old)) begin
      nx = tab_read(old) & LINK_MASK;
      fat_tab[int'(old)] = FREE_WORD;
      if (free_cnt != MAX_COUNT) free_cnt++;
      old = nx;
    end
    close_request(st, first);
  endfunction

  function automatic void model_request(logic [2:0] f, logic [31:0] cl, logic us,
                                        logic [6:0] rl, logic [31:0] wv);
    step_out.delete();
    case (f)
      FUNC_WALK:  chain_pass(cl, 1'b0);
      FUNC_WRITE: chain_write(us, cl, rl);
      FUNC_FREE:  chain_pass(cl, 1'b1);
      FUNC_LOAD, FUNC_READ: begin
        if (cl >= TAB_SIZE) begin
          add_result(ST_BAD, cl, 32'd0, 32'd0, 0, 1'b1);
        end else begin
          if (f == FUNC_LOAD) fat_tab[int'(cl)] = wv;
          add_result(ST_OK, cl, 32'd0, tab_read(cl), 0, 1'b1);
        end
      end
      FUNC_SET: begin
        free_cnt = wv;
        hint = cl;
        add_result(ST_OK, cl, 32'd0, 32'd0, 0, 1'b1);
      end
      default: add_result(ST_OK, 32'd0, 32'd0, 32'd0, 0, 1'b1);
    endcase
    foreach (step_out[k]) step_out[k].free_clusters = free_cnt;
  endfunction

  // ---------------------------------------------------------------- driving
  // one request transaction; dropped if it would read an unwritten entry
  task automatic send_request(logic [2:0] f, logic [31:0] cl, logic us,
                              logic [6:0] rl, logic [31:0] wv);
    logic [31:0] tab_save [int];
    logic [31:0] free_save, hint_save;
    tab_save = fat_tab;
    free_save = free_cnt;
    hint_save = hint;
    hit_unwritten = 1'b0;
    model_request(f, cl, us, rl, wv);
    if (hit_unwritten) begin
      fat_tab = tab_save;
      free_cnt = free_save;
      hint = hint_save;
      return;
    end
    pending_results = {pending_results, step_out};
    in_valid <= 1'b1;
    func <= f;
    cluster <= cl;
    use_start <= us;
    run_length <= rl;
    word_value <= wv;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    sent_count++;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (4) @(posedge clk);
  endtask

  // writes all three registers; block must be idle
  task automatic set_config(logic [31:0] base, logic [7:0] sectors, logic [16:0] total);
    cfg_write <= 1'b1;
    cfg_index <= REG_DATA_START;
    cfg_data <= base;
    @(posedge clk);
    cfg_index <= REG_SECT_CLUS;
    cfg_data <= {24'd0, sectors};
    @(posedge clk);
    cfg_index <= REG_CLUS_TOTAL;
    cfg_data <= {15'd0, total};
    @(posedge clk);
    cfg_write <= 1'b0;
    base_sector = base;
    spc = sectors;
    total_reg = total;
  endtask

  // ---------------------------------------------------------------- checking
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %0h expected %0h", what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    link_result_t w;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, cluster_id", cluster_id, 32'd0);
      end else begin
        w = pending_results.pop_front();
        if (status !== w.status) report_mismatch("status", status, w.status);
        if (cluster_id !== w.cluster_id) report_mismatch("cluster_id", cluster_id, w.cluster_id);
        if (sector_address !== w.sector_address)
          report_mismatch("sector_address", sector_address, w.sector_address);
        if (entry_word !== w.entry_word) report_mismatch("entry_word", entry_word, w.entry_word);
        if (link_count !== w.link_count) report_mismatch("link_count", link_count, w.link_count);
        if (free_clusters !== w.free_clusters)
          report_mismatch("free_clusters", free_clusters, w.free_clusters);
        if (last !== w.last) report_mismatch("last", last, w.last);
      end
    end
    // receiver stall bursts
    if (quiet) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 6);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- tests
  task automatic test_reset_and_init();
    set_config(32'h0000_1000, 8'd8, 17'd80);
    for (int i = 0; i < INIT_SPAN; i++)
      send_request(FUNC_LOAD, i, 1'b0, 7'd1, FREE_WORD);
    send_request(FUNC_SET, NO_HINT, 1'b0, 7'd1, 32'd1000);
  endtask

  // chain longer than the link limit, then a saturating free
  task automatic test_long_chain();
    send_request(FUNC_WRITE, 32'd2, 1'b1, 7'd64, 32'd0);
    send_request(FUNC_LOAD, 32'd65, 1'b0, 7'd1, 32'd66);
    send_request(FUNC_LOAD, 32'd66, 1'b0, 7'd1, END_WORD);
    send_request(FUNC_WALK, 32'd2, 1'b0, 7'd1, 32'd0);
    send_request(FUNC_SET, NO_HINT, 1'b0, 7'd1, 32'hFFFF_FFF0);
    send_request(FUNC_FREE, 32'd2, 1'b0, 7'd1, 32'd0);
    send_request(FUNC_FREE, 32'd66, 1'b0, 7'd1, 32'd0);
  endtask

  task automatic test_empty_starts();
    send_request(FUNC_WALK, 32'd0, 1'b0, 7'd1, 32'd0);
    send_request(FUNC_WALK, END_MIN, 1'b0, 7'd1, 32'd0);
    send_request(FUNC_FREE, END_WORD, 1'b0, 7'd1, 32'd0);
    send_request(FUNC_WALK, 32'd1, 1'b0, 7'd1, 32'd0);
  endtask

  task automatic test_write_chain();
    send_request(FUNC_SET, NO_HINT, 1'b0, 7'd1, 32'd3);
    send_request(FUNC_WRITE, 32'd0, 1'b0, 7'd0, 32'd0);
    send_request(FUNC_WRITE, 32'd0, 1'b0, 7'd5, 32'd0);
    send_request(FUNC_SET, NO_HINT, 1'b0, 7'd1, 32'd1000);
    send_request(FUNC_WRITE, 32'd80, 1'b1, 7'd4, 32'd0);
    send_request(FUNC_WRITE, 32'd1, 1'b1, 7'd4, 32'd0);
    send_request(FUNC_WRITE, 32'd0, 1'b0, 7'd5, 32'd0);
    send_request(FUNC_WALK, 32'd2, 1'b0, 7'd1, 32'd0);
    // shorter rewrite over the same start frees the tail
    send_request(FUNC_WRITE, 32'd2, 1'b1, 7'd3, 32'd0);
    // table runs out part way
    wait_idle();
    set_config(32'hFFFF_FF00, 8'd128, 17'd10);
    send_request(FUNC_SET, 32'd2, 1'b0, 7'd1, 32'd1000);
    send_request(FUNC_WRITE, 32'd0, 1'b0, 7'd20, 32'd0);
    send_request(FUNC_WRITE, 32'd0, 1'b0, 7'd2, 32'd0);
    wait_idle();
    set_config(32'd0, 8'd1, 17'd80);
    send_request(FUNC_WRITE, 32'd0, 1'b0, 7'd127, 32'd0);
  endtask

  task automatic test_bad_link();
    send_request(FUNC_LOAD, 32'd70, 1'b0, 7'd1, BAD_WORD);
    send_request(FUNC_WALK, 32'd70, 1'b0, 7'd1, 32'd0);
    send_request(FUNC_WALK, BAD_WORD, 1'b0, 7'd1, 32'd0);
    send_request(FUNC_FREE, 32'd70, 1'b0, 7'd1, 32'd0);
  endtask

  task automatic test_table_access();
    send_request(FUNC_READ, 32'd0, 1'b0, 7'd1, 32'd0);
    send_request(FUNC_LOAD, 32'hFFFF_FFFF, 1'b0, 7'd1, 32'hA5A5_A5A5);
    send_request(FUNC_READ, 32'd65536, 1'b0, 7'd1, 32'd0);
    send_request(FUNC_LOAD, 32'd79, 1'b0, 7'd1, $urandom);
    send_request(FUNC_READ, 32'd79, 1'b0, 7'd1, 32'd0);
    send_request(3'd6, $urandom, 1'b1, 7'd64, $urandom);
    send_request(3'd7, $urandom, 1'b0, 7'd127, $urandom);
  endtask

  function automatic logic [31:0] pick_start(logic [31:0] span);
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return END_MIN | $urandom_range(0, 7);
      2: return BAD_WORD;
      default: return $urandom_range(0, span + 2);
    endcase
  endfunction

  function automatic logic [31:0] pick_word(logic [31:0] span);
    case ($urandom_range(0, 7))
      0: return FREE_WORD;
      1: return END_WORD;
      2: return BAD_WORD;
      3: return $urandom;
      4: return END_MIN | $urandom_range(0, 7);
      default: return $urandom_range(0, span + 2);
    endcase
  endfunction

  task automatic test_random_traffic();
    logic [31:0] span, cl, wv;
    logic [6:0]  rl;
    logic [16:0] total;
    int          pick, phase_start;
    phase_start = sent_count;
    span = INIT_SPAN;
    while (sent_count - phase_start < RANDOM_ITEMS) begin
      if (sent_count - phase_start >= QUIET_FROM) quiet = 1'b1;
      // new setting every so often
      if ((sent_count - phase_start) % 55 == 54) begin
        wait_idle();
        case ($urandom_range(0, 5))
          0: total = 17'd2;
          1: total = 17'd80;
          2: total = 17'd65536;
          3: total = 17'h1FFFF;
          default: total = $urandom_range(3, 80);
        endcase
        set_config(($urandom_range(0, 1) == 0) ? 32'd0 : $urandom,
                   ($urandom_range(0, 2) == 0) ? 8'd1 :
                   ($urandom_range(0, 1) == 0) ? 8'd128 : 8'($urandom_range(1, 128)),
                   total);
        send_request(FUNC_SET, NO_HINT, 1'b0, 7'd1, $urandom_range(20, 200));
      end
      span = (eff_total() > INIT_SPAN) ? INIT_SPAN : eff_total();
      rl = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127))
                                       : 7'($urandom_range(1, 8));
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        cl = ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, span + 1);
        send_request(FUNC_WRITE, cl, 1'($urandom_range(0, 1)), rl, $urandom);
      end else if (pick < 50) begin
        send_request(FUNC_WALK, pick_start(span), 1'($urandom), rl, $urandom);
      end else if (pick < 65) begin
        send_request(FUNC_FREE, pick_start(span), 1'($urandom), rl, $urandom);
      end else if (pick < 88) begin
        cl = ($urandom_range(0, 7) == 0) ? $urandom_range(TAB_SIZE, 32'hFFFF_FFFF)
                                         : $urandom_range(0, INIT_SPAN - 1);
        send_request(($urandom_range(0, 1) == 0) ? FUNC_LOAD : FUNC_READ, cl,
                     1'($urandom), rl, pick_word(span));
      end else if (pick < 97) begin
        case ($urandom_range(0, 3))
          0: cl = NO_HINT;
          1: cl = $urandom;
          default: cl = $urandom_range(0, span + 2);
        endcase
        case ($urandom_range(0, 3))
          0: wv = $urandom;
          1: wv = MAX_COUNT;
          default: wv = $urandom_range(0, 100);
        endcase
        send_request(FUNC_SET, cl, 1'($urandom), rl, wv);
      end else begin
        send_request(3'($urandom_range(6, 7)), $urandom, 1'($urandom), rl, $urandom);
      end
    end
  endtask

  // ---------------------------------------------------------------- sequence
  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_DATA_START;
    cfg_data = '0;
    in_valid = 1'b0;
    func = FUNC_WALK;
    cluster = '0;
    use_start = 1'b0;
    run_length = '0;
    word_value = '0;
    out_stall = 1'b0;
    free_cnt = '0;
    hint = NO_HINT;
    base_sector = '0;
    spc = 8'd8;
    total_reg = 17'd65536;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_and_init();
    test_long_chain();
    test_empty_starts();
    test_write_chain();
    test_bad_link();
    test_table_access();
    test_random_traffic();

    quiet = 1'b1;
    wait_idle();
    repeat (16) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/fcce_pkg.sv
rtl/fcce_ctrl.sv
rtl/fcce_dp.sv
rtl/fat_cluster_chain_engine.sv
bench/tb_top.sv
